// ===== rtl/core/booth_radix2_signed_multiplier_macros.svh =====
// ----------------------------------------------------------------------------
// Booth multiplier assertion macros
// Shared concurrent assertion forms for the multiplier modules.
// ----------------------------------------------------------------------------
`ifndef BOOTH_RADIX2_SIGNED_MULTIPLIER_MACROS_SVH
`define BOOTH_RADIX2_SIGNED_MULTIPLIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRM_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("BRM assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BRM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("BRM assertion failed");

`endif

// ===== rtl/core/brm_pkg.sv =====
// ----------------------------------------------------------------------------
// Booth multiplier package
// Fixed field widths, defaults and the radix-2 Booth recoding.
// ----------------------------------------------------------------------------
package brm_pkg;

    localparam int CFG_W       = 6;
    localparam int OPERAND_W   = 32;
    localparam int IN_DATA_W   = 2 * OPERAND_W;
    localparam int OUT_DATA_W  = 64;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd8;

    typedef enum logic [1:0]
    {
        BOOTH_NOP,
        BOOTH_ADD,
        BOOTH_SUB
    } booth_op_t;

    // The pair (Q0, Q-1) picks the accumulator operation.
    function automatic booth_op_t booth_decode(input logic q0, input logic qm1);
        booth_op_t op;
        case ({q0, qm1})
            2'b01:   op = BOOTH_ADD;
            2'b10:   op = BOOTH_SUB;
            default: op = BOOTH_NOP;
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/core/brm_cell.sv =====
// ----------------------------------------------------------------------------
// Booth step cell
// One radix-2 Booth step followed by a register stage with valid/ready.
// ----------------------------------------------------------------------------
`include "booth_radix2_signed_multiplier_macros.svh"

module brm_cell #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W:0]   in_acc,
    input  logic [W-1:0] in_q,
    input  logic         in_qm1,
    input  logic [W-1:0] in_m,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W:0]   out_acc,
    output logic [W-1:0] out_q,
    output logic         out_qm1,
    output logic [W-1:0] out_m
);
    import brm_pkg::*;

    logic         valid_reg;
    logic [W:0]   acc_reg;
    logic [W-1:0] q_reg;
    logic         qm1_reg;
    logic [W-1:0] m_reg;

    logic [W:0]   acc_next;
    logic [W-1:0] q_next;
    logic         qm1_next;
    logic [W:0]   sum;
    logic [W:0]   m_ext;
    booth_op_t    op;
    logic         load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign m_ext    = {in_m[W-1], in_m};
    assign op       = booth_decode(in_q[0], in_qm1);

    always_comb
    begin
        case (op)
            BOOTH_ADD: sum = in_acc + m_ext;
            BOOTH_SUB: sum = in_acc - m_ext;
            default:   sum = in_acc;
        endcase
        // Arithmetic right shift of A:Q:Q-1 by one place.
        acc_next = {sum[W], sum[W:1]};
        q_next   = {sum[0], in_q[W-1:1]};
        qm1_next = in_q[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg <= acc_next;
            q_reg   <= q_next;
            qm1_reg <= qm1_next;
            m_reg   <= in_m;
        end
    end

    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
    assign out_q     = q_reg;
    assign out_qm1   = qm1_reg;
    assign out_m     = m_reg;

    // After the shift the guard bit always repeats the sign of A.
    `BRM_ASSERT_SAME(a_guard_sign, clk, rst_n, valid_reg, acc_reg[W] == acc_reg[W-1])
    `BRM_ASSERT_NEXT(a_m_carried, clk, rst_n, load, m_reg == $past(in_m))
    `BRM_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, valid_reg && !out_ready,
        valid_reg && $stable(acc_reg) && $stable(q_reg))

endmodule

// ===== rtl/core/booth_radix2_signed_multiplier.sv =====
// Each input transfer passes every step cell register before its product is on m_tvalid.
// Throughput: one operand pair per cycle unless stalled; a chain of MAX_OPERAND_BITS
// Booth step cells, each with its own register and valid bit, does one recoding step
// per cycle. Output stalls fill empty cells first; the input keeps taking items until
// the chain is full. Reset clears every valid bit and sets the operand width to 8.
// ----------------------------------------------------------------------------
// Signed radix-2 Booth multiplier
// Sign-extends both operands to the cell width and runs them through the
// step chain; the product is A:Q of the last cell, sign-extended to 64 bits.
// ----------------------------------------------------------------------------
`include "booth_radix2_signed_multiplier_macros.svh"

module booth_radix2_signed_multiplier #(
    parameter int MAX_OPERAND_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [brm_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] multiplicand, [63:32] multiplier
    input  logic [brm_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [63:0] product
    output logic [brm_pkg::OUT_DATA_W-1:0] m_tdata
);
    import brm_pkg::*;

    localparam int W     = MAX_OPERAND_BITS;
    localparam int IDX_W = $clog2(W);
    localparam logic [CFG_W-1:0] MAX_N = CFG_W'(W);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] eff_n;
    logic [IDX_W-1:0] sign_idx;
    logic [OPERAND_W-1:0] mcand;
    logic [OPERAND_W-1:0] mplier;
    logic [W-1:0] q_ext;
    logic [W-1:0] m_ext;

    logic         valid_c [0:W];
    logic         ready_c [0:W];
    logic [W:0]   acc_c   [0:W];
    logic [W-1:0] q_c     [0:W];
    logic         qm1_c   [0:W];
    logic [W-1:0] m_c     [0:W];

    logic signed [2*W-1:0] prod_w;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            width_reg <= cfg_data;
        end
    end

    // A width of zero acts as one; widths past the chain length saturate.
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_n = CFG_W'(1);
        end
        else if (width_reg > MAX_N)
        begin
            eff_n = MAX_N;
        end
        else
        begin
            eff_n = width_reg;
        end
    end

    assign sign_idx = IDX_W'(eff_n - CFG_W'(1));
    assign mcand    = s_tdata[OPERAND_W-1:0];
    assign mplier   = s_tdata[IN_DATA_W-1:OPERAND_W];

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            if (CFG_W'(i) < eff_n)
            begin
                q_ext[i] = mcand[i];
                m_ext[i] = mplier[i];
            end
            else
            begin
                q_ext[i] = mcand[sign_idx];
                m_ext[i] = mplier[sign_idx];
            end
        end
    end

    assign valid_c[0] = s_tvalid;
    assign s_tready   = ready_c[0];
    assign acc_c[0]   = '0;
    assign q_c[0]     = q_ext;
    assign qm1_c[0]   = 1'b0;
    assign m_c[0]     = m_ext;

    for (genvar g = 0; g < W; g++)
    begin : g_step
        brm_cell #(
            .W(W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (valid_c[g]),
            .in_ready (ready_c[g]),
            .in_acc   (acc_c[g]),
            .in_q     (q_c[g]),
            .in_qm1   (qm1_c[g]),
            .in_m     (m_c[g]),
            .out_valid(valid_c[g+1]),
            .out_ready(ready_c[g+1]),
            .out_acc  (acc_c[g+1]),
            .out_q    (q_c[g+1]),
            .out_qm1  (qm1_c[g+1]),
            .out_m    (m_c[g+1])
        );
    end

    assign ready_c[W] = m_tready;
    assign m_tvalid   = valid_c[W];

    // The exact product fits in 2W bits, so the guard bit can be dropped.
    assign prod_w  = {acc_c[W][W-1:0], q_c[W]};
    assign m_tdata = OUT_DATA_W'(prod_w);

    `BRM_ASSERT_NEXT(a_cfg_taken, clk, rst_n, cfg_valid, width_reg == $past(cfg_data))
    `BRM_ASSERT_SAME(a_width_range, clk, rst_n, 1'b1,
        (eff_n != '0) && (eff_n <= MAX_N) && (32'(sign_idx) < W))
    `BRM_ASSERT_SAME(a_product_sext, clk, rst_n, m_tvalid,
        (&m_tdata[OUT_DATA_W-1:2*W-1]) || !(|m_tdata[OUT_DATA_W-1:2*W-1]))

endmodule
